@@ rtl/gcoc_pkg.sv @@
// Shared constants for the gripper close/open controller: widths, mode codes,
// register indexes and reset values. Depends on nothing.
`timescale 1ns / 1ps

package gcoc_pkg;

   // Width of the wrapping tick counters (range 16 to 64).
   localparam int TIME_WIDTH = 32;

   localparam int ANGLE_W    = 8;
   localparam int PRESSURE_W = 10;
   localparam int TICKS_W    = 16;
   localparam int MODE_W     = 3;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int INDEX_W    = 3;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [MODE_W-1:0]     mode_type;

   localparam mode_type MODE_OPEN    = 3'd0;
   localparam mode_type MODE_CLOSING = 3'd1;
   localparam mode_type MODE_CLOSED  = 3'd2;
   localparam mode_type MODE_OPENING = 3'd3;
   localparam mode_type MODE_ERROR   = 3'd4;

   localparam logic [INDEX_W-1:0] REG_OPEN_POSITION   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_CLOSED_POSITION = 3'd1;
   localparam logic [INDEX_W-1:0] REG_STEP_INTERVAL   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_CLOSE_TIMEOUT   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_CONTACT_DELTA   = 3'd4;
   localparam logic [INDEX_W-1:0] REG_PULSE_LENGTH    = 3'd5;

   localparam logic [ANGLE_W-1:0]    RST_OPEN_POSITION   = 8'd30;
   localparam logic [ANGLE_W-1:0]    RST_CLOSED_POSITION = 8'd110;
   localparam logic [TICKS_W-1:0]    RST_STEP_INTERVAL   = 16'd15;
   localparam logic [TICKS_W-1:0]    RST_CLOSE_TIMEOUT   = 16'd1800;
   localparam logic [PRESSURE_W-1:0] RST_CONTACT_DELTA   = 10'd20;
   localparam logic [TICKS_W-1:0]    RST_PULSE_LENGTH    = 16'd50;

   // Ticks between two counter values, modulo the counter width.
   function automatic time_type elapsed(input time_type now_t, input time_type then_t);
      return now_t - then_t;
   endfunction

endpackage

@@ rtl/gripper_close_open_controller_top.sv @@
// Top level of the gripper close/open controller: register port, five-mode
// state machine, handshake pulse timer and result register. Uses gcoc_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   close_command, pressure_sample
// rsp       out        rsp_valid/rsp_stall   servo_angle, mode, holding, fault,
//                                            handshake_level
// csr       in/out     psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// The whole tick is worked out by compare and add logic between the state
// registers and the result register, so a new word is accepted in every
// cycle while the result register is free or being emptied. The result is
// registered and appears in the cycle after acceptance. Reset is
// synchronous and puts the controller in open at the reset open position
// with all counters cleared. While a result is stalled, req_stall is raised
// and the state holds.

module gripper_close_open_controller_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_close_command,
   input  logic [gcoc_pkg::PRESSURE_W-1:0]   req_pressure_sample,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gcoc_pkg::ANGLE_W-1:0]      rsp_servo_angle,
   output logic [gcoc_pkg::MODE_W-1:0]       rsp_mode,
   output logic                              rsp_holding,
   output logic                              rsp_fault,
   output logic                              rsp_handshake_level,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gcoc_pkg::ADDR_W-1:0]       paddr,
   input  logic [gcoc_pkg::DATA_W-1:0]       pwdata,
   output logic [gcoc_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   // Configuration registers.
   logic [gcoc_pkg::ANGLE_W-1:0]    open_position_ff;
   logic [gcoc_pkg::ANGLE_W-1:0]    closed_position_ff;
   logic [gcoc_pkg::TICKS_W-1:0]    step_interval_ff;
   logic [gcoc_pkg::TICKS_W-1:0]    close_timeout_ff;
   logic [gcoc_pkg::PRESSURE_W-1:0] contact_delta_ff;
   logic [gcoc_pkg::TICKS_W-1:0]    pulse_length_ff;

   logic                            cfg_write;
   logic [gcoc_pkg::INDEX_W-1:0]    cfg_index;

   // Controller state.
   gcoc_pkg::mode_type              mode_ff, mode_in;
   logic [gcoc_pkg::ANGLE_W-1:0]    position_ff, position_in;
   logic [gcoc_pkg::PRESSURE_W-1:0] baseline_ff, baseline_in;
   logic                            fault_ff, fault_in;
   logic                            pulse_high_ff, pulse_high_in;
   gcoc_pkg::time_type              tick_ff, tick_in;
   gcoc_pkg::time_type              last_step_ff, last_step_in;
   gcoc_pkg::time_type              close_start_ff, close_start_in;
   gcoc_pkg::time_type              pulse_start_ff, pulse_start_in;
   logic                            holding_in;

   // Result register.
   logic                            rsp_valid_ff;
   logic [gcoc_pkg::ANGLE_W-1:0]    rsp_angle_ff;
   gcoc_pkg::mode_type              rsp_mode_ff;
   logic                            rsp_holding_ff;
   logic                            rsp_fault_ff;
   logic                            rsp_level_ff;

   logic                            accept;
   logic                            step_due;
   logic                            pulse_expired;
   logic                            pulse_live;
   logic                            pulse_req;
   logic                            contact;
   logic                            timed_out;
   logic [gcoc_pkg::ANGLE_W-1:0]    stepped;
   logic [gcoc_pkg::PRESSURE_W:0]   threshold;

   // ---------------------------------------------------------------------
   // Register port. Writes land at the access phase; reads are a plain mux.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[gcoc_pkg::ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         open_position_ff   <= gcoc_pkg::RST_OPEN_POSITION;
         closed_position_ff <= gcoc_pkg::RST_CLOSED_POSITION;
         step_interval_ff   <= gcoc_pkg::RST_STEP_INTERVAL;
         close_timeout_ff   <= gcoc_pkg::RST_CLOSE_TIMEOUT;
         contact_delta_ff   <= gcoc_pkg::RST_CONTACT_DELTA;
         pulse_length_ff    <= gcoc_pkg::RST_PULSE_LENGTH;
      end else if (cfg_write) begin
         case (cfg_index)
            gcoc_pkg::REG_OPEN_POSITION: begin
               open_position_ff <= pwdata[gcoc_pkg::ANGLE_W-1:0];
            end
            gcoc_pkg::REG_CLOSED_POSITION: begin
               closed_position_ff <= pwdata[gcoc_pkg::ANGLE_W-1:0];
            end
            gcoc_pkg::REG_STEP_INTERVAL: begin
               step_interval_ff <= pwdata[gcoc_pkg::TICKS_W-1:0];
            end
            gcoc_pkg::REG_CLOSE_TIMEOUT: begin
               close_timeout_ff <= pwdata[gcoc_pkg::TICKS_W-1:0];
            end
            gcoc_pkg::REG_CONTACT_DELTA: begin
               contact_delta_ff <= pwdata[gcoc_pkg::PRESSURE_W-1:0];
            end
            gcoc_pkg::REG_PULSE_LENGTH: begin
               pulse_length_ff <= pwdata[gcoc_pkg::TICKS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (cfg_index)
         gcoc_pkg::REG_OPEN_POSITION:   prdata = gcoc_pkg::DATA_W'(open_position_ff);
         gcoc_pkg::REG_CLOSED_POSITION: prdata = gcoc_pkg::DATA_W'(closed_position_ff);
         gcoc_pkg::REG_STEP_INTERVAL:   prdata = gcoc_pkg::DATA_W'(step_interval_ff);
         gcoc_pkg::REG_CLOSE_TIMEOUT:   prdata = gcoc_pkg::DATA_W'(close_timeout_ff);
         gcoc_pkg::REG_CONTACT_DELTA:   prdata = gcoc_pkg::DATA_W'(contact_delta_ff);
         gcoc_pkg::REG_PULSE_LENGTH:    prdata = gcoc_pkg::DATA_W'(pulse_length_ff);
         default:                       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake. The input is held off only while a result sits unclaimed.
   // ---------------------------------------------------------------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // One tick of the controller. The current tick count is "now"; the
   // pulse timer is serviced before the mode logic may request a new pulse.
   // ---------------------------------------------------------------------
   assign step_due      = gcoc_pkg::elapsed(tick_ff, last_step_ff) >=
                          gcoc_pkg::TIME_WIDTH'(step_interval_ff);
   assign timed_out     = gcoc_pkg::elapsed(tick_ff, close_start_ff) >=
                          gcoc_pkg::TIME_WIDTH'(close_timeout_ff);
   assign pulse_expired = gcoc_pkg::elapsed(tick_ff, pulse_start_ff) >=
                          gcoc_pkg::TIME_WIDTH'(pulse_length_ff);
   assign pulse_live    = pulse_high_ff && !pulse_expired;
   assign threshold     = {1'b0, baseline_ff} + {1'b0, contact_delta_ff};
   assign contact       = {1'b0, req_pressure_sample} > threshold;

   always_comb begin
      mode_in        = mode_ff;
      position_in    = position_ff;
      baseline_in    = baseline_ff;
      fault_in       = fault_ff;
      last_step_in   = last_step_ff;
      close_start_in = close_start_ff;
      holding_in     = 1'b0;
      pulse_req      = 1'b0;
      stepped        = position_ff;

      case (mode_ff)
         gcoc_pkg::MODE_OPEN: begin
            fault_in    = 1'b0;
            baseline_in = req_pressure_sample;
            if (req_close_command) begin
               close_start_in = tick_ff;
               mode_in        = gcoc_pkg::MODE_CLOSING;
            end
         end
         gcoc_pkg::MODE_CLOSING: begin
            if (step_due) begin
               last_step_in = tick_ff;
               if (position_ff < closed_position_ff) begin
                  stepped = position_ff + 1'b1;
               end
            end
            position_in = stepped;
            // Contact takes priority over the limit and the timeout.
            if (contact) begin
               fault_in   = 1'b0;
               mode_in    = gcoc_pkg::MODE_CLOSED;
               pulse_req  = 1'b1;
               holding_in = 1'b1;
            end else if (stepped >= closed_position_ff || timed_out) begin
               fault_in   = 1'b1;
               mode_in    = gcoc_pkg::MODE_ERROR;
               holding_in = 1'b1;
            end
         end
         gcoc_pkg::MODE_CLOSED, gcoc_pkg::MODE_ERROR: begin
            if (!req_close_command) begin
               mode_in = gcoc_pkg::MODE_OPENING;
            end
            holding_in = 1'b1;
         end
         default: begin
            if (step_due) begin
               last_step_in = tick_ff;
               if (position_ff > open_position_ff) begin
                  stepped = position_ff - 1'b1;
               end
            end
            position_in = stepped;
            // Arriving at or below the open position snaps to it exactly.
            if (stepped <= open_position_ff) begin
               position_in = open_position_ff;
               baseline_in = req_pressure_sample;
               fault_in    = 1'b0;
               mode_in     = gcoc_pkg::MODE_OPEN;
               pulse_req   = 1'b1;
            end
         end
      endcase

      // A request while the pulse is still high is dropped.
      pulse_high_in  = pulse_live;
      pulse_start_in = pulse_start_ff;
      if (pulse_req && !pulse_live) begin
         pulse_high_in  = 1'b1;
         pulse_start_in = tick_ff;
      end

      tick_in = tick_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= gcoc_pkg::MODE_OPEN;
         position_ff    <= gcoc_pkg::RST_OPEN_POSITION;
         baseline_ff    <= '0;
         fault_ff       <= 1'b0;
         pulse_high_ff  <= 1'b0;
         tick_ff        <= '0;
         last_step_ff   <= '0;
         close_start_ff <= '0;
         pulse_start_ff <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         position_ff    <= position_in;
         baseline_ff    <= baseline_in;
         fault_ff       <= fault_in;
         pulse_high_ff  <= pulse_high_in;
         tick_ff        <= tick_in;
         last_step_ff   <= last_step_in;
         close_start_ff <= close_start_in;
         pulse_start_ff <= pulse_start_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register. It refills on the same edge at which it is emptied.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_angle_ff   <= position_in;
         rsp_mode_ff    <= mode_in;
         rsp_holding_ff <= holding_in;
         rsp_fault_ff   <= fault_in;
         rsp_level_ff   <= pulse_high_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_servo_angle     = rsp_angle_ff;
   assign rsp_mode            = rsp_mode_ff;
   assign rsp_holding         = rsp_holding_ff;
   assign rsp_fault           = rsp_fault_ff;
   assign rsp_handshake_level = rsp_level_ff;

endmodule

@@ sim/gripper_close_open_controller_top_tb.sv @@
// Self-checking testbench for the gripper close/open controller: tick words in,
// predicted status words checked out, register settings changed between phases.
// Depends on gcoc_pkg and gripper_close_open_controller_top.
`timescale 1ns / 1ps

module gripper_close_open_controller_top_tb;

   localparam int HALF_HIGH    = 6;
   localparam int HALF_LOW     = 6;
   localparam int RESET_CYCLES = 9;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int SETTLE_TICKS = 3;

   // Indexes past the register list; writes there must change nothing.
   localparam logic [gcoc_pkg::INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [gcoc_pkg::INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                            close_cmd;
      logic [gcoc_pkg::PRESSURE_W-1:0] pressure;
   } tick_word_type;

   typedef struct packed {
      logic [gcoc_pkg::ANGLE_W-1:0] angle;
      gcoc_pkg::mode_type           mode;
      logic                         holding;
      logic                         fault;
      logic                         handshake;
   } grip_status_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_close_command = 1'b0;
   logic [gcoc_pkg::PRESSURE_W-1:0] req_pressure_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [gcoc_pkg::ANGLE_W-1:0]    rsp_servo_angle;
   logic [gcoc_pkg::MODE_W-1:0]     rsp_mode;
   logic                            rsp_holding;
   logic                            rsp_fault;
   logic                            rsp_handshake_level;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [gcoc_pkg::ADDR_W-1:0]     paddr = '0;
   logic [gcoc_pkg::DATA_W-1:0]     pwdata = '0;
   logic [gcoc_pkg::DATA_W-1:0]     prdata;
   logic                            pready;

   gripper_close_open_controller_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_close_command   (req_close_command),
      .req_pressure_sample (req_pressure_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_servo_angle     (rsp_servo_angle),
      .rsp_mode            (rsp_mode),
      .rsp_holding         (rsp_holding),
      .rsp_fault           (rsp_fault),
      .rsp_handshake_level (rsp_handshake_level),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #HALF_HIGH clock = 1'b1;
      #HALF_LOW  clock = 1'b0;
   end

   // Tick words waiting to be sent, and the status words they are expected
   // to produce, oldest first.
   tick_word_type   tick_q[$];
   grip_status_type status_q[$];

   // The controller as the testbench understands it: its register settings
   // and its state, advanced once per accepted tick word.
   logic [gcoc_pkg::ANGLE_W-1:0]    lim_open, lim_closed;
   logic [gcoc_pkg::TICKS_W-1:0]    step_gap, close_limit, pulse_len;
   logic [gcoc_pkg::PRESSURE_W-1:0] touch_delta;
   gcoc_pkg::mode_type              grip_mode;
   logic [gcoc_pkg::ANGLE_W-1:0]    grip_angle;
   logic [gcoc_pkg::PRESSURE_W-1:0] grip_baseline;
   logic                            grip_fault, pulse_on;
   gcoc_pkg::time_type              tick_now, last_step_at, close_began_at, pulse_began_at;

   int  words_queued = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  fail_count = 0;
   int  contacts = 0;
   int  faults = 0;
   int  reopens = 0;
   int  settings_used = 1;
   int  quiet_cycles = 0;
   int  send_wait = 0;
   int  recv_wait = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // A new pulse request is ignored while the handshake pulse is still high.
   task automatic request_pulse(input gcoc_pkg::time_type now_t);
      if (!pulse_on) begin
         pulse_on = 1'b1;
         pulse_began_at = now_t;
      end
   endtask

   // One millisecond tick: service the pulse, run the mode machine, then
   // advance the tick counter. The status word reflects the state after it.
   task automatic step_gripper(input tick_word_type w, output grip_status_type s);
      gcoc_pkg::time_type now_t, since_pulse, since_step, since_close;
      logic               touch;
      begin
         now_t = tick_now;
         since_pulse = now_t - pulse_began_at;
         since_step = now_t - last_step_at;
         since_close = now_t - close_began_at;
         touch = 1'b0;
         if (pulse_on && since_pulse >= pulse_len)
            pulse_on = 1'b0;
         case (grip_mode)
            gcoc_pkg::MODE_OPEN: begin
               grip_fault = 1'b0;
               grip_baseline = w.pressure;
               if (w.close_cmd) begin
                  close_began_at = now_t;
                  grip_mode = gcoc_pkg::MODE_CLOSING;
               end
            end
            gcoc_pkg::MODE_CLOSING: begin
               if (since_step >= step_gap) begin
                  last_step_at = now_t;
                  if (grip_angle < lim_closed)
                     grip_angle = grip_angle + 1'b1;
               end
               // Contact takes priority over the angle limit and the timeout.
               if (int'(w.pressure) > int'(grip_baseline) + int'(touch_delta)) begin
                  grip_fault = 1'b0;
                  grip_mode = gcoc_pkg::MODE_CLOSED;
                  request_pulse(now_t);
                  touch = 1'b1;
                  contacts++;
               end else if (grip_angle >= lim_closed || since_close >= close_limit) begin
                  grip_fault = 1'b1;
                  grip_mode = gcoc_pkg::MODE_ERROR;
                  touch = 1'b1;
                  faults++;
               end
            end
            gcoc_pkg::MODE_CLOSED, gcoc_pkg::MODE_ERROR: begin
               if (!w.close_cmd)
                  grip_mode = gcoc_pkg::MODE_OPENING;
               touch = 1'b1;
            end
            default: begin
               if (since_step >= step_gap) begin
                  last_step_at = now_t;
                  if (grip_angle > lim_open)
                     grip_angle = grip_angle - 1'b1;
               end
               // An angle below the open position snaps up to it.
               if (grip_angle <= lim_open) begin
                  grip_angle = lim_open;
                  grip_baseline = w.pressure;
                  grip_fault = 1'b0;
                  grip_mode = gcoc_pkg::MODE_OPEN;
                  request_pulse(now_t);
                  reopens++;
               end
            end
         endcase
         tick_now = tick_now + 1'b1;
         s.angle = grip_angle;
         s.mode = grip_mode;
         s.holding = touch;
         s.fault = grip_fault;
         s.handshake = pulse_on;
      end
   endtask

   // Each side draws a random wait per word while its idling is enabled, and no wait otherwise.
   function automatic int draw_wait(input bit idle_on);
      if (!idle_on || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   // Word capture: every accepted tick word advances the prediction.
   always @(posedge clock) begin : req_capture
      grip_status_type next_s;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         step_gripper('{req_close_command, req_pressure_sample}, next_s);
         status_q.push_back(next_s);
         words_sent++;
      end
   end

   // Word driver. A word stays on the port until it is accepted; then the
   // drawn wait runs out before the next word goes up.
   always @(negedge clock) begin : req_drive
      tick_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (req_valid && !req_taken) begin
         // Held: the payload must not change while stalled.
      end else if (send_wait > 0) begin
         req_valid <= 1'b0;
         send_wait--;
      end else if (tick_q.size() > 0) begin
         w = tick_q.pop_front();
         req_close_command <= w.close_cmd;
         req_pressure_sample <= w.pressure;
         req_valid <= 1'b1;
         send_wait = draw_wait(send_idle);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result checker: each accepted status word against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      grip_status_type want, got;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_servo_angle, rsp_mode, rsp_holding, rsp_fault, rsp_handshake_level};
         if (status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: status word with nothing expected: angle %0d mode %0d",
                        $realtime, got.angle, got.mode);
         end else begin
            want = status_q.pop_front();
            words_checked++;
            if (got.angle !== want.angle || got.mode !== want.mode ||
                got.holding !== want.holding || got.fault !== want.fault ||
                got.handshake !== want.handshake) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"%0t: word %0d mismatch: expected angle %0d mode %0d hold %0b ",
                            "fault %0b pulse %0b, got angle %0d mode %0d hold %0b ",
                            "fault %0b pulse %0b"},
                           $realtime, words_checked, want.angle, want.mode, want.holding,
                           want.fault, want.handshake, got.angle, got.mode, got.holding,
                           got.fault, got.handshake);
            end
         end
      end
   end

   // Result stall: a fresh wait is drawn after every accepted status word.
   always @(negedge clock) begin : rsp_drive
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_taken)
            recv_wait = draw_wait(recv_idle);
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: too long without any word moving or any register access.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles, %0d words still expected.",
                  quiet_cycles, status_q.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Wait until every queued word has gone and every expected word has come,
   // then let the result register settle.
   task automatic settle();
      while (tick_q.size() != 0 || req_valid || status_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic write_reg(input logic [gcoc_pkg::INDEX_W-1:0] idx,
                            input logic [gcoc_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         gcoc_pkg::REG_OPEN_POSITION:   lim_open = value[gcoc_pkg::ANGLE_W-1:0];
         gcoc_pkg::REG_CLOSED_POSITION: lim_closed = value[gcoc_pkg::ANGLE_W-1:0];
         gcoc_pkg::REG_STEP_INTERVAL:   step_gap = value[gcoc_pkg::TICKS_W-1:0];
         gcoc_pkg::REG_CLOSE_TIMEOUT:   close_limit = value[gcoc_pkg::TICKS_W-1:0];
         gcoc_pkg::REG_CONTACT_DELTA:   touch_delta = value[gcoc_pkg::PRESSURE_W-1:0];
         gcoc_pkg::REG_PULSE_LENGTH:    pulse_len = value[gcoc_pkg::TICKS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic add_word(input logic cmd, input int press);
      tick_word_type w;
      w.close_cmd = cmd;
      w.pressure = (press > 1023) ? 10'd1023 : press[gcoc_pkg::PRESSURE_W-1:0];
      tick_q.push_back(w);
      words_queued++;
   endtask

   // One grasp: settle a baseline while open, close with pressure kept at or
   // under the contact threshold, usually touch something, hold, then release.
   task automatic add_grasp();
      int base, quiet_top, n;
      base = $urandom_range(0, 1023);
      quiet_top = base + int'(touch_delta);
      if (quiet_top > 1023)
         quiet_top = 1023;
      n = $urandom_range(1, 3);
      repeat (n) add_word(1'b0, base);
      // The word that starts closing still sets the baseline, so it carries base.
      add_word(1'b1, base);
      n = $urandom_range(0, 25);
      repeat (n) add_word(1'b1, $urandom_range(base, quiet_top));
      if ($urandom_range(0, 3) != 0)
         add_word(1'b1, base + int'(touch_delta) + 1 + $urandom_range(0, 60));
      n = $urandom_range(0, 10);
      repeat (n) add_word(1'b1, $urandom_range(0, 1023));
      n = $urandom_range(1, 45);
      repeat (n) add_word(1'b0, $urandom_range(0, 1023));
   endtask

   // Mostly well-formed grasps, with the odd burst of random words.
   task automatic add_random_ticks(input int count);
      int target;
      target = words_queued + count;
      while (words_queued < target) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 8))
               add_word(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
         else
            add_grasp();
      end
   endtask

   // A phase: drain the controller (the sender holds off until every
   // expected word is back), write all registers plus one spare index,
   // pick which sides idle, then queue the words.
   task automatic run_phase(input int idx, input int o, input int c, input int s,
                            input int t, input int d, input int p, input int count);
      settle();
      write_reg(gcoc_pkg::REG_OPEN_POSITION, o);
      write_reg(gcoc_pkg::REG_CLOSED_POSITION, c);
      write_reg(gcoc_pkg::REG_STEP_INTERVAL, s);
      write_reg(gcoc_pkg::REG_CLOSE_TIMEOUT, t);
      write_reg(gcoc_pkg::REG_CONTACT_DELTA, d);
      write_reg(gcoc_pkg::REG_PULSE_LENGTH, p);
      write_reg(idx[0] ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      settings_used++;
      send_idle = (idx % 4 == 0) || (idx % 4 == 1);
      recv_idle = (idx % 4 == 0) || (idx % 4 == 2);
      add_random_ticks(count);
   endtask

   initial begin : stimulus
      int ph, o, c, s, t, d, p;
      lim_open = gcoc_pkg::RST_OPEN_POSITION;
      lim_closed = gcoc_pkg::RST_CLOSED_POSITION;
      step_gap = gcoc_pkg::RST_STEP_INTERVAL;
      close_limit = gcoc_pkg::RST_CLOSE_TIMEOUT;
      touch_delta = gcoc_pkg::RST_CONTACT_DELTA;
      pulse_len = gcoc_pkg::RST_PULSE_LENGTH;
      grip_mode = gcoc_pkg::MODE_OPEN;
      grip_angle = gcoc_pkg::RST_OPEN_POSITION;
      grip_baseline = '0;
      grip_fault = 1'b0;
      pulse_on = 1'b0;
      tick_now = '0;
      last_step_at = '0;
      close_began_at = '0;
      pulse_began_at = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings. Full-scale and zero
      // pressure while open, pressure exactly at the contact threshold
      // (no contact) and one above it, full-scale contact, then release.
      add_word(1'b0, 1023);
      add_word(1'b0, 0);
      add_word(1'b1, 0);
      add_word(1'b1, 20);
      add_word(1'b1, 21);
      add_word(1'b1, 1023);
      add_word(1'b0, 512);
      add_word(1'b0, 0);
      add_word(1'b0, 0);
      add_word(1'b1, 0);
      add_word(1'b1, 1023);
      add_word(1'b1, 300);
      add_word(1'b0, 1);
      add_word(1'b0, 1023);
      add_word(1'b0, 5);
      add_random_ticks(80);

      // Low extremes: steps on every tick, zero timeout, any rise is contact,
      // one-tick pulses, and an open position below the current angle.
      run_phase(1, 0, 180, 0, 0, 0, 0, 90);
      // High extremes: the angle already sits at the limit when closing
      // starts, and opening finds the angle below the open position.
      run_phase(2, 180, 0, 65535, 65535, 1023, 65535, 90);
      // Back to the reset values through the port.
      run_phase(3, int'(gcoc_pkg::RST_OPEN_POSITION), int'(gcoc_pkg::RST_CLOSED_POSITION),
                int'(gcoc_pkg::RST_STEP_INTERVAL), int'(gcoc_pkg::RST_CLOSE_TIMEOUT),
                int'(gcoc_pkg::RST_CONTACT_DELTA), int'(gcoc_pkg::RST_PULSE_LENGTH), 90);

      // Random settings with short travel so that closing reaches its limit,
      // its timeout and contact alike.
      for (ph = 4; ph < 10; ph++) begin
         o = $urandom_range(0, 170);
         if ($urandom_range(0, 9) == 0) begin
            c = $urandom_range(0, o);
         end else begin
            c = o + $urandom_range(0, 25);
            if (c > 180)
               c = 180;
         end
         s = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
         t = $urandom_range(0, 80);
         d = $urandom_range(0, 150);
         p = $urandom_range(0, 30);
         run_phase(ph, o, c, s, t, d, p, 95);
      end

      settle();
      $display("Sent %0d tick words under %0d register settings, checked %0d status words.",
               words_sent, settings_used, words_checked);
      $display("Saw %0d contacts, %0d faults and %0d returns to open; %0d mismatches.",
               contacts, faults, reopens, fail_count);
      if (fail_count == 0 && status_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gcoc_pkg.sv
rtl/gripper_close_open_controller_top.sv
sim/gripper_close_open_controller_top_tb.sv
